// ===== rtl/ntip_pkg.sv =====
`timescale 1ns / 1ps

package ntip_pkg;

    // Default geometry of the tag image
    localparam int IMAGE_BYTES_DEF = 120;
    localparam int AREA_FIRST_DEF  = 12;
    localparam int AREA_LAST_DEF   = 103;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 7;
    localparam int LEN_W       = 7;
    localparam int ST_W        = 2;
    localparam int SKIP_W      = 2;
    localparam int REM_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // Capability container and TLV codes
    localparam int               CC_POS   = 8;
    localparam logic [BYTE_W-1:0] CC_MAGIC = 8'hE1;
    localparam logic [BYTE_W-1:0] T_NULL   = 8'h00;
    localparam logic [BYTE_W-1:0] T_TERM   = 8'hFE;
    localparam logic [BYTE_W-1:0] T_LONG   = 8'hFF;
    localparam logic [BYTE_W-1:0] T_NDEF   = 8'h03;

    // Final status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_NOCC  = 2'd2;
    localparam logic [ST_W-1:0] ST_OVF   = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY    = 2'd1;

    typedef enum logic [2:0] {
        PH_PRE,
        PH_TYPE,
        PH_LEN1,
        PH_LENHI,
        PH_LENLO,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE
    } t_phase;

    // One queue entry: an optional payload beat followed by an optional status beat
    typedef struct packed {
        logic              has_payload;
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_last;
        logic              has_status;
        logic [ST_W-1:0]   status;
        logic [LEN_W-1:0]  message_length;
    } t_entry;

endpackage

// ===== rtl/ntip_if.sv =====
`timescale 1ns / 1ps

interface ntip_in_if;
    logic                        valid;
    logic                        ready;
    logic [ntip_pkg::BYTE_W-1:0] image_byte;
    logic                        image_last;

    modport source (output valid, output image_byte, output image_last, input ready);
    modport sink   (input valid, input image_byte, input image_last, output ready);
endinterface

interface ntip_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ntip_pkg::BYTE_W-1:0] payload_byte;
    logic                        payload_last;
    logic [ntip_pkg::ST_W-1:0]   status;
    logic [ntip_pkg::LEN_W-1:0]  message_length;

    modport source (output valid, output kind, output payload_byte, output payload_last,
                    output status, output message_length, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_last,
                    input status, input message_length, output ready);
endinterface

interface ntip_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ntip_pkg::CFG_INDEX_W-1:0] index;
    logic [ntip_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ndef_tlv_image_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                               Beat
// i_img     in   image_byte[7:0], image_last                            one image byte
// i_cfg     in   index[1:0], data[6:0]                                  one register write
// o_res     out  kind, payload_byte[7:0], payload_last, status[1:0],
//                message_length[6:0]                                   one result item
//
// One image byte is taken per cycle whenever the result queue has room; the byte is parsed
// and its entry written to the queue at the edge that accepts it, and the entry leaves the
// queue into the output register at the next edge when that register is free. A byte that
// yields both a payload byte and the final status gives a payload beat, then a status beat,
// while the queue holds its next entry; o_res carries one beat per cycle while the receiver
// is ready. Reset is synchronous, active low, and returns the parser to the start of an
// image with header_skip 0, capacity 92.
// i_img stalls only when the queue is full; i_cfg never stalls.

module ndef_tlv_image_parser_unit #(
    parameter int IMAGE_BYTES = ntip_pkg::IMAGE_BYTES_DEF,
    parameter int AREA_FIRST  = ntip_pkg::AREA_FIRST_DEF,
    parameter int AREA_LAST   = ntip_pkg::AREA_LAST_DEF,
    parameter int QUEUE_DEPTH = ntip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntip_in_if.sink     i_img,
    ntip_cfg_if.sink    i_cfg,
    ntip_out_if.source  o_res
);

    // Front to queue
    logic             push;
    logic             full;
    ntip_pkg::t_entry push_entry;

    // Queue to back
    logic             q_valid;
    logic             pop;
    ntip_pkg::t_entry q_entry;

    // Front: skip header, check the container, walk TLVs, classify each byte
    ntip_front #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .AREA_FIRST  (AREA_FIRST),
        .AREA_LAST   (AREA_LAST)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_img   (i_img),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // Hold entries while the sink stalls, so the front keeps taking bytes
    ntip_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Back: split each entry into its payload and status beats
    ntip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/ntip_front.sv =====
`timescale 1ns / 1ps

module ntip_front #(
    parameter int IMAGE_BYTES = ntip_pkg::IMAGE_BYTES_DEF,
    parameter int AREA_FIRST  = ntip_pkg::AREA_FIRST_DEF,
    parameter int AREA_LAST   = ntip_pkg::AREA_LAST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ntip_in_if.sink           i_img,
    ntip_cfg_if.sink          i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output ntip_pkg::t_entry  o_entry
);

    localparam int AREA_END   = (AREA_LAST < IMAGE_BYTES) ? AREA_LAST : IMAGE_BYTES - 1;
    localparam int WALK_MIN   = ntip_pkg::CC_POS + 1;
    localparam int WALK_FIRST = (AREA_FIRST > WALK_MIN) ? AREA_FIRST : WALK_MIN;
    localparam int PW         = ntip_pkg::POS_W + 1;

    ntip_pkg::t_phase                  r_phase, n_phase, w_phase, len_phase;
    logic [ntip_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [ntip_pkg::SKIP_W-1:0]       r_hdr_cnt, n_hdr_cnt;
    logic                              r_is_ndef, n_is_ndef;
    logic [ntip_pkg::BYTE_W-1:0]       r_len_hi, n_len_hi;
    logic [ntip_pkg::REM_W-1:0]        r_rem, n_rem;
    logic [ntip_pkg::ST_W-1:0]         r_found_status, n_found_status, w_found_status;
    logic [ntip_pkg::LEN_W-1:0]        r_found_len, n_found_len, w_found_len;
    logic [ntip_pkg::SKIP_W-1:0]       r_skip;
    logic [ntip_pkg::LEN_W-1:0]        r_cap;

    logic                              accept, hdr_en, walk_en, last;
    logic [ntip_pkg::BYTE_W-1:0]       b;
    logic [PW-1:0]                     pos_p1, pos_p2, avail;
    logic [ntip_pkg::REM_W-1:0]        len_in;
    logic [ntip_pkg::LEN_W-1:0]        len_clip;
    logic                              ovf, full, emit;

    assign i_img.ready = !i_full;
    assign i_cfg.ready = 1'b1;

    assign accept  = i_img.valid && !i_full;
    assign b       = i_img.image_byte;
    assign last    = i_img.image_last;
    assign hdr_en  = accept && (r_hdr_cnt < r_skip);
    assign walk_en = accept && !(r_hdr_cnt < r_skip) && (r_pos < ntip_pkg::POS_W'(IMAGE_BYTES));

    // Length handling shared by the one- and three-byte length forms
    always_comb begin
        pos_p1 = {1'b0, r_pos} + PW'(1);
        pos_p2 = {1'b0, r_pos} + PW'(2);
        avail  = (pos_p1 <= PW'(AREA_END)) ? PW'(AREA_END + 1) - pos_p1 : '0;
        len_in = (r_phase == ntip_pkg::PH_LENLO) ? {r_len_hi, b} : {8'h00, b};
        len_clip = (len_in > {8'h00, avail}) ? avail[ntip_pkg::LEN_W-1:0]
                                              : len_in[ntip_pkg::LEN_W-1:0];
        ovf = len_clip > r_cap;
        if (r_is_ndef) begin
            len_phase = (ovf || len_clip == '0) ? ntip_pkg::PH_DONE : ntip_pkg::PH_PAYLOAD;
        end else begin
            len_phase = (len_in == '0) ? ntip_pkg::PH_TYPE : ntip_pkg::PH_SKIP;
        end
    end

    // Next phase
    always_comb begin
        w_phase = r_phase;
        case (r_phase)
            ntip_pkg::PH_PRE: begin
                if (r_pos == ntip_pkg::POS_W'(ntip_pkg::CC_POS) && b != ntip_pkg::CC_MAGIC) begin
                    w_phase = ntip_pkg::PH_DONE;
                end else if (pos_p1 >= PW'(WALK_FIRST)) begin
                    w_phase = (WALK_FIRST > AREA_END) ? ntip_pkg::PH_DONE : ntip_pkg::PH_TYPE;
                end
            end
            ntip_pkg::PH_TYPE: begin
                if (b == ntip_pkg::T_TERM) begin
                    w_phase = ntip_pkg::PH_DONE;
                end else if (b != ntip_pkg::T_NULL) begin
                    w_phase = ntip_pkg::PH_LEN1;
                end
            end
            ntip_pkg::PH_LEN1: begin
                if (b == ntip_pkg::T_LONG) begin
                    w_phase = (pos_p2 > PW'(AREA_END)) ? ntip_pkg::PH_DONE : ntip_pkg::PH_LENHI;
                end else begin
                    w_phase = len_phase;
                end
            end
            ntip_pkg::PH_LENHI:   w_phase = ntip_pkg::PH_LENLO;
            ntip_pkg::PH_LENLO:   w_phase = len_phase;
            ntip_pkg::PH_PAYLOAD: begin
                if (r_rem == ntip_pkg::REM_W'(1)) w_phase = ntip_pkg::PH_DONE;
            end
            ntip_pkg::PH_SKIP: begin
                if (r_rem == ntip_pkg::REM_W'(1)) w_phase = ntip_pkg::PH_TYPE;
            end
            default: w_phase = ntip_pkg::PH_DONE;
        endcase
        // Close the walk at the data-area end
        if (w_phase != ntip_pkg::PH_PRE && w_phase != ntip_pkg::PH_DONE &&
            w_phase != ntip_pkg::PH_PAYLOAD && {1'b0, r_pos} >= PW'(AREA_END)) begin
            w_phase = ntip_pkg::PH_DONE;
        end

        n_phase = r_phase;
        if (accept && last) begin
            n_phase = ntip_pkg::PH_PRE;
        end else if (walk_en) begin
            n_phase = w_phase;
        end
    end

    // Datapath and queue entry
    always_comb begin
        n_is_ndef      = r_is_ndef;
        n_len_hi       = r_len_hi;
        n_rem          = r_rem;
        w_found_status = r_found_status;
        w_found_len    = r_found_len;
        emit           = 1'b0;
        if (walk_en) begin
            case (r_phase)
                ntip_pkg::PH_PRE: begin
                    if (r_pos == ntip_pkg::POS_W'(ntip_pkg::CC_POS) &&
                        b != ntip_pkg::CC_MAGIC) begin
                        w_found_status = ntip_pkg::ST_NOCC;
                    end
                end
                ntip_pkg::PH_TYPE: begin
                    if (b != ntip_pkg::T_TERM && b != ntip_pkg::T_NULL) begin
                        n_is_ndef = (b == ntip_pkg::T_NDEF);
                    end
                end
                ntip_pkg::PH_LEN1, ntip_pkg::PH_LENLO: begin
                    if (r_phase == ntip_pkg::PH_LENLO || b != ntip_pkg::T_LONG) begin
                        if (r_is_ndef) begin
                            w_found_len = len_clip;
                            if (ovf) w_found_status = ntip_pkg::ST_OVF;
                            n_rem = {9'd0, len_clip};
                        end else begin
                            n_rem = len_in;
                        end
                    end
                end
                ntip_pkg::PH_LENHI: n_len_hi = b;
                ntip_pkg::PH_PAYLOAD: begin
                    n_rem = r_rem - ntip_pkg::REM_W'(1);
                    emit  = 1'b1;
                end
                ntip_pkg::PH_SKIP: n_rem = r_rem - ntip_pkg::REM_W'(1);
                default: ;
            endcase
        end

        n_pos     = walk_en ? r_pos + ntip_pkg::POS_W'(1) : r_pos;
        n_hdr_cnt = hdr_en ? r_hdr_cnt + ntip_pkg::SKIP_W'(1) : r_hdr_cnt;
        full      = n_pos >= ntip_pkg::POS_W'(IMAGE_BYTES);

        o_entry.has_payload    = emit;
        o_entry.payload_byte   = b;
        o_entry.payload_last   = (r_rem == ntip_pkg::REM_W'(1));
        o_entry.has_status     = last;
        o_entry.status         = full ? w_found_status : ntip_pkg::ST_SHORT;
        o_entry.message_length = full ? w_found_len : '0;
        o_push                 = accept && (emit || last);

        n_found_status = w_found_status;
        n_found_len    = w_found_len;
        // Restart all parse state once the image ends
        if (accept && last) begin
            n_pos          = '0;
            n_hdr_cnt      = '0;
            n_is_ndef      = 1'b0;
            n_len_hi       = '0;
            n_rem          = '0;
            n_found_status = ntip_pkg::ST_OK;
            n_found_len    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ntip_pkg::PH_PRE;
            r_pos          <= '0;
            r_hdr_cnt      <= '0;
            r_is_ndef      <= 1'b0;
            r_len_hi       <= '0;
            r_rem          <= '0;
            r_found_status <= ntip_pkg::ST_OK;
            r_found_len    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_hdr_cnt      <= n_hdr_cnt;
            r_is_ndef      <= n_is_ndef;
            r_len_hi       <= n_len_hi;
            r_rem          <= n_rem;
            r_found_status <= n_found_status;
            r_found_len    <= n_found_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
            r_cap  <= ntip_pkg::LEN_W'(92);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ntip_pkg::REG_HEADER_SKIP: r_skip <= i_cfg.data[ntip_pkg::SKIP_W-1:0];
                ntip_pkg::REG_CAPACITY:    r_cap  <= i_cfg.data[ntip_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/ntip_queue.sv =====
`timescale 1ns / 1ps

module ntip_queue #(
    parameter int QUEUE_DEPTH = ntip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ntip_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ntip_pkg::t_entry o_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ntip_pkg::t_entry   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full   = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_entry  = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        if (do_pop)  n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        if (do_push && !do_pop) n_cnt = r_cnt + CNT_W'(1);
        if (!do_push && do_pop) n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/ntip_back.sv =====
`timescale 1ns / 1ps

module ntip_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ntip_pkg::t_entry i_entry,
    output logic             o_pop,
    ntip_out_if.source       o_res
);

    logic                          r_valid, n_valid;
    logic                          r_kind, n_kind;
    logic [ntip_pkg::BYTE_W-1:0]   r_byte, n_byte;
    logic                          r_plast, n_plast;
    logic [ntip_pkg::ST_W-1:0]     r_status, n_status;
    logic [ntip_pkg::LEN_W-1:0]    r_len, n_len;
    logic                          r_pend, n_pend;
    logic [ntip_pkg::ST_W-1:0]     r_pend_status, n_pend_status;
    logic [ntip_pkg::LEN_W-1:0]    r_pend_len, n_pend_len;
    logic                          load;

    assign load  = !r_valid || o_res.ready;
    assign o_pop = load && !r_pend && i_valid;

    always_comb begin
        n_valid       = r_valid;
        n_kind        = r_kind;
        n_byte        = r_byte;
        n_plast       = r_plast;
        n_status      = r_status;
        n_len         = r_len;
        n_pend        = r_pend;
        n_pend_status = r_pend_status;
        n_pend_len    = r_pend_len;
        if (load) begin
            if (r_pend) begin
                // Second beat of a split entry
                n_valid  = 1'b1;
                n_kind   = ntip_pkg::KIND_STATUS;
                n_byte   = '0;
                n_plast  = 1'b0;
                n_status = r_pend_status;
                n_len    = r_pend_len;
                n_pend   = 1'b0;
            end else if (i_valid) begin
                n_valid = 1'b1;
                if (i_entry.has_payload) begin
                    n_kind        = ntip_pkg::KIND_PAYLOAD;
                    n_byte        = i_entry.payload_byte;
                    n_plast       = i_entry.payload_last;
                    n_status      = ntip_pkg::ST_OK;
                    n_len         = '0;
                    n_pend        = i_entry.has_status;
                    n_pend_status = i_entry.status;
                    n_pend_len    = i_entry.message_length;
                end else begin
                    n_kind   = ntip_pkg::KIND_STATUS;
                    n_byte   = '0;
                    n_plast  = 1'b0;
                    n_status = i_entry.status;
                    n_len    = i_entry.message_length;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_byte        <= n_byte;
        r_plast       <= n_plast;
        r_status      <= n_status;
        r_len         <= n_len;
        r_pend_status <= n_pend_status;
        r_pend_len    <= n_pend_len;
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_kind;
    assign o_res.payload_byte   = r_byte;
    assign o_res.payload_last   = r_plast;
    assign o_res.status         = r_status;
    assign o_res.message_length = r_len;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ntip_pkg::*;

    // Image geometry of the default build, worked out here from the package
    localparam int IMG_LEN    = IMAGE_BYTES_DEF;
    localparam int AREA_END   = (AREA_LAST_DEF < IMG_LEN) ? AREA_LAST_DEF : IMG_LEN - 1;
    localparam int WALK_FIRST = (AREA_FIRST_DEF > 9) ? AREA_FIRST_DEF : 9;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // One result beat as the checker sees it
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] pbyte;
        logic              plast;
        logic [ST_W-1:0]   status;
        logic [LEN_W-1:0]  mlen;
    } t_result_beat;

    // Shapes of generated tag images
    typedef enum int {
        SH_SHORT_NDEF,
        SH_LONG_NDEF,
        SH_NO_CC,
        SH_TERM_FIRST,
        SH_EMPTY_NDEF,
        SH_TRUNC_TLV,
        SH_SKIP_PAST,
        SH_NOISE,
        SH_CUT_SHORT,
        SH_EXTRA,
        SH_COUNT
    } t_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ntip_in_if  img_if ();
    ntip_cfg_if cfg_if ();
    ntip_out_if res_if ();

    ndef_tlv_image_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_img   (img_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats still owed by the block, oldest first
    t_result_beat pending_results[$];

    // Shadow registers, tracked as the writes are accepted
    logic [SKIP_W-1:0] cfg_hdr_skip = '0;
    logic [LEN_W-1:0]  cfg_capacity = 7'd92;

    // Parser state of the shadow model
    int                pos;
    t_phase            phase;
    logic [BYTE_W-1:0] tlv_type;
    int                len_acc;
    int                left_bytes;
    int                hdr_seen;
    logic [ST_W-1:0]   found_st;
    logic [LEN_W-1:0]  found_len;

    // Stimulus controls and run statistics
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int errors        = 0;
    int images_sent   = 0;
    int bytes_sent    = 0;
    int settings_seen = 0;
    int payload_seen  = 0;
    int status_seen   = 0;
    int shape_idx     = 0;

    logic [BYTE_W-1:0] img_buf[128];
    int                img_len;

    // ------------------------------------------------------------------
    // Shadow model of the parser
    // ------------------------------------------------------------------
    function automatic void restart_parse();
        pos        = 0;
        phase      = PH_PRE;
        tlv_type   = '0;
        len_acc    = 0;
        left_bytes = 0;
        hdr_seen   = 0;
        found_st   = ST_OK;
        found_len  = '0;
    endfunction

    // Length of a TLV is complete at image byte p: clip an NDEF length to what
    // is left of the data area, then stream, flag overflow, or skip.
    function automatic void close_length(int p, int len);
        int avail;
        avail = (p + 1 <= AREA_END) ? AREA_END - p : 0;
        if (tlv_type == T_NDEF) begin
            if (len > avail)
                len = avail;
            found_len = LEN_W'(len);
            if (len > cfg_capacity) begin
                found_st = ST_OVF;
                phase    = PH_DONE;
            end else if (len == 0) begin
                phase = PH_DONE;
            end else begin
                left_bytes = len;
                phase      = PH_PAYLOAD;
            end
        end else if (len == 0) begin
            phase = PH_TYPE;
        end else begin
            left_bytes = len;
            phase      = PH_SKIP;
        end
    endfunction

    function automatic void step_walk(int p, logic [BYTE_W-1:0] b);
        case (phase)
            PH_PRE: begin
                if (p == CC_POS && b != CC_MAGIC) begin
                    found_st = ST_NOCC;
                    phase    = PH_DONE;
                end else if (p + 1 >= WALK_FIRST) begin
                    phase = (WALK_FIRST > AREA_END) ? PH_DONE : PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b == T_TERM) begin
                    phase = PH_DONE;
                end else if (b != T_NULL) begin
                    tlv_type = b;
                    phase    = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (b == T_LONG)
                    phase = (p + 2 > AREA_END) ? PH_DONE : PH_LENHI;
                else
                    close_length(p, b);
            end
            PH_LENHI: begin
                len_acc = b << 8;
                phase   = PH_LENLO;
            end
            PH_LENLO: begin
                len_acc = len_acc | b;
                close_length(p, len_acc);
            end
            PH_PAYLOAD: begin
                left_bytes--;
                pending_results.push_back({KIND_PAYLOAD, b, left_bytes == 0, ST_OK, 7'd0});
                if (left_bytes == 0)
                    phase = PH_DONE;
            end
            PH_SKIP: begin
                left_bytes--;
                if (left_bytes == 0)
                    phase = PH_TYPE;
            end
            default: ;
        endcase
        // A walk still looking for TLV fields stops at the end of the data area
        if (phase != PH_PRE && phase != PH_DONE && phase != PH_PAYLOAD && p >= AREA_END)
            phase = PH_DONE;
    endfunction

    function automatic void parse_byte(logic [BYTE_W-1:0] b, logic last);
        logic full;
        if (hdr_seen < cfg_hdr_skip) begin
            hdr_seen++;
        end else if (pos < IMG_LEN) begin
            step_walk(pos, b);
            pos++;
        end
        if (last) begin
            full = (pos >= IMG_LEN);
            pending_results.push_back({KIND_STATUS, 8'd0, 1'b0,
                                       full ? found_st : ST_SHORT,
                                       full ? found_len : 7'd0});
            restart_parse();
        end
    endfunction

    initial restart_parse();

    // Predict from every accepted image beat
    always @(posedge i_clk) begin
        if (i_rst_n && img_if.valid && img_if.ready)
            parse_byte(img_if.image_byte, img_if.image_last);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result_beat exp_b;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got kind %0d byte %0d status %0d",
                         $time, res_if.kind, res_if.payload_byte, res_if.status);
                errors++;
            end else begin
                exp_b = pending_results.pop_front();
                check_field("kind", exp_b.kind, res_if.kind);
                check_field("payload_byte", exp_b.pbyte, res_if.payload_byte);
                check_field("payload_last", exp_b.plast, res_if.payload_last);
                check_field("status", exp_b.status, res_if.status);
                check_field("message_length", exp_b.mlen, res_if.message_length);
                if (exp_b.kind == KIND_STATUS)
                    status_seen++;
                else
                    payload_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted down here
    // ------------------------------------------------------------------
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((img_if.valid && img_if.ready) || (res_if.valid && res_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired with %0d beats outstanding", $time,
                 pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one image beat, idling at random first; leave valid high on return
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            img_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        img_if.valid      <= 1'b1;
        img_if.image_byte <= b;
        img_if.image_last <= last;
        do @(posedge i_clk); while (!img_if.ready);
        bytes_sent++;
    endtask

    // Drop valid, let the predictor see the final beat, and wait until every
    // owed beat is back, then let the parser settle
    task automatic drain();
        img_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers back to back; call only with the block idle
    task automatic set_registers(input logic [SKIP_W-1:0] hs, input logic [LEN_W-1:0] cap);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_HEADER_SKIP;
        cfg_if.data  <= CFG_DATA_W'(hs);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_hdr_skip = hs;
        cfg_if.index <= REG_CAPACITY;
        cfg_if.data  <= cap;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_capacity = cap;
        cfg_if.valid <= 1'b0;
        settings_seen++;
    endtask

    // Fill img_buf with a tag image of the given shape and set img_len
    task automatic build_image(input t_shape shape, input int min_len);
        int w, n, len, k;
        logic [BYTE_W-1:0] prop;
        for (int i = 0; i < 128; i++)
            img_buf[i] = BYTE_W'($urandom_range(255));
        img_buf[CC_POS] = CC_MAGIC;
        img_len = IMG_LEN;
        w = WALK_FIRST;

        // Lead in with a few NULL and proprietary TLVs
        n = $urandom_range(3);
        repeat (n) begin
            if ($urandom_range(1)) begin
                img_buf[w] = T_NULL;
                w++;
            end else begin
                prop = BYTE_W'($urandom_range(1, 253));
                if (prop == T_NDEF)
                    prop = 8'h02;
                len = $urandom_range(4);
                img_buf[w]     = prop;
                img_buf[w + 1] = BYTE_W'(len);
                w += 2 + len;
            end
        end

        case (shape)
            SH_NO_CC:      img_buf[CC_POS] = CC_MAGIC ^ BYTE_W'($urandom_range(1, 255));
            SH_TERM_FIRST: begin
                img_buf[w] = T_TERM;
                w++;
            end
            SH_EMPTY_NDEF: begin
                img_buf[w]     = T_NDEF;
                img_buf[w + 1] = 8'h00;
                w += 2;
            end
            default: ;
        endcase

        // Plain NDEF message closed by a terminator; shapes below rework it
        len = $urandom_range(min_len, 40);
        img_buf[w]           = T_NDEF;
        img_buf[w + 1]       = BYTE_W'(len);
        img_buf[w + 2 + len] = T_TERM;

        case (shape)
            SH_LONG_NDEF: begin
                // Three-byte length: mostly in range, sometimes far past the area
                len = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 90);
                img_buf[w + 1] = T_LONG;
                img_buf[w + 2] = BYTE_W'(len >> 8);
                img_buf[w + 3] = BYTE_W'(len);
            end
            SH_TRUNC_TLV: begin
                for (int i = WALK_FIRST; i <= AREA_END; i++)
                    img_buf[i] = T_NULL;
                k = $urandom_range(3);
                case (k)
                    0: img_buf[AREA_END] = T_NDEF;
                    1: begin
                        img_buf[AREA_END - 1] = T_NDEF;
                        img_buf[AREA_END]     = T_LONG;
                    end
                    2: begin
                        img_buf[AREA_END - 2] = 8'h10;
                        img_buf[AREA_END - 1] = T_LONG;
                    end
                    default: begin
                        img_buf[AREA_END - 1] = T_NDEF;
                        img_buf[AREA_END]     = BYTE_W'($urandom_range(254));
                    end
                endcase
            end
            SH_SKIP_PAST: begin
                img_buf[w] = 8'hC0;
                if ($urandom_range(1)) begin
                    img_buf[w + 1] = T_LONG;
                    img_buf[w + 2] = BYTE_W'($urandom_range(255));
                    img_buf[w + 3] = 8'hF0;
                end else begin
                    img_buf[w + 1] = BYTE_W'($urandom_range(AREA_END - w, 254));
                end
            end
            SH_NOISE: begin
                for (int i = WALK_FIRST; i <= AREA_END; i++)
                    img_buf[i] = BYTE_W'($urandom_range(255));
            end
            SH_CUT_SHORT: begin
                // Mostly end inside the payload, which can end both beats in one step
                if ($urandom_range(3) != 0)
                    img_len = $urandom_range(w + 3, w + 2 + len);
                else
                    img_len = $urandom_range(1, IMG_LEN - 1);
            end
            SH_EXTRA:      img_len = IMG_LEN + $urandom_range(1, 7);
            default: ;
        endcase
    endtask

    // Send the header bytes, then the image, marking the final beat
    task automatic send_image();
        for (int i = 0; i < cfg_hdr_skip; i++)
            send_byte(BYTE_W'($urandom_range(255)), 1'b0);
        for (int i = 0; i < img_len; i++)
            send_byte(img_buf[i], i == img_len - 1);
        images_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short images: image end on the first byte, inside the header with a header skip of three,
    // on the capability container byte, and on the first byte again with the header skip at zero
    task automatic test_short_images();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(8'hFF, 1'b1);
        drain();
        set_registers(2'd3, 7'd0);
        send_byte(8'h00, 1'b1);
        drain();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        for (int i = 0; i < CC_POS; i++)
            send_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
        send_byte(CC_MAGIC, 1'b1);
        drain();
        set_registers(2'd0, 7'd127);
        send_byte(8'hAA, 1'b1);
        drain();
        images_sent += 4;
    endtask

    // Whole tag images, shapes taken in turn, under random register settings
    task automatic test_tag_images(input int count, input int s_idle, input int r_idle);
        logic [LEN_W-1:0] cap;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count) begin
            drain();
            case ($urandom_range(4))
                0:       cap = 7'd0;
                1:       cap = 7'd92;
                2:       cap = 7'd127;
                default: cap = LEN_W'($urandom_range(1, 91));
            endcase
            set_registers(SKIP_W'($urandom_range(3)), cap);
            build_image(t_shape'(shape_idx % SH_COUNT), 1);
            shape_idx++;
            send_image();
        end
        drain();
    endtask

    // Hold the receiver off while a long message streams, so the queue fills
    // and the image channel stalls
    task automatic test_full_queue();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        set_registers(2'd0, 7'd92);
        build_image(SH_SHORT_NDEF, 30);
        hold_cycles = HOLD_CYCLES;
        send_image();
        drain();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        img_if.valid      <= 1'b0;
        img_if.image_byte <= '0;
        img_if.image_last <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_HEADER_SKIP;
        cfg_if.data       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_images();
        test_tag_images(4, 30, 76);
        test_tag_images(4, 76, 30);
        test_tag_images(4, 0, 0);
        test_full_queue();
        drain();

        $display("Ran %0d images (%0d image beats) over %0d register settings,", images_sent,
                 bytes_sent, settings_seen);
        $display("checking %0d payload beats and %0d status beats.", payload_seen, status_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ntip_pkg.sv
rtl/ntip_if.sv
rtl/ntip_front.sv
rtl/ntip_queue.sv
rtl/ntip_back.sv
rtl/ndef_tlv_image_parser_unit.sv
verif/tb.sv
